FILE: src/fl2p_pkg.sv
// ----------------------------------------------------------------------------
// fl2p_pkg: shared constants and types for the fast log2 datapath
// Fixed-point formats, polynomial coefficients and pipeline context.
// ----------------------------------------------------------------------------
package fl2p_pkg;

    // Internal fraction bits (Q24) and output word width
    localparam int Q                  = 24;
    localparam int LOG_W              = 25;
    localparam int OUT_FRAC_BITS_DEF  = 16;

    // Width of the polynomial accumulator and number of Horner coefficients
    localparam int P_W                = 27;
    localparam int NUM_COEF           = 6;

    // Pipeline depth: decode, 5 Horner steps of two stages, (m-1) scale,
    // exponent add, ln 2 multiply, ln 2 round, output round and clamp
    localparam int NUM_STAGES         = 16;

    // ln 2 in Q24
    localparam logic signed [24:0] LN2_Q24 = 25'sd11629080;

    // Horner coefficients in Q24, highest degree first
    localparam logic signed [P_W-1:0] COEF [NUM_COEF] = '{
        -27'sd577740,
         27'sd5338734,
        -27'sd20661650,
         27'sd43601387,
        -27'sd55770805,
         27'sd52274280
    };

    // Per-item context that travels down the pipe
    typedef struct packed {
        logic [22:0]       frac;
        logic signed [8:0] expo;
        logic              minf;
    } t_ctx;

endpackage

FILE: src/fl2p_in_if.sv
// ----------------------------------------------------------------------------
// fl2p_in_if: input item channel
// Carries the raw single-precision bit pattern with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fl2p_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

FILE: src/fl2p_out_if.sv
// ----------------------------------------------------------------------------
// fl2p_out_if: result item channel
// Carries the fixed-point logarithm and the minus-infinity flag.
// ----------------------------------------------------------------------------
interface fl2p_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fl2p_pkg::LOG_W-1:0]  log_value;
    logic                               minus_infinity;

    modport source (output valid, output log_value, output minus_infinity, input ready);
    modport sink   (input valid, input log_value, input minus_infinity, output ready);
endinterface

FILE: src/fl2p_cfg_if.sv
// ----------------------------------------------------------------------------
// fl2p_cfg_if: configuration write channel
// Writes the natural-log mode register with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fl2p_cfg_if;
    logic valid;
    logic ready;
    logic natural_log_mode;

    modport source (output valid, output natural_log_mode, input ready);
    modport sink   (input valid, input natural_log_mode, output ready);
endinterface

FILE: src/fast_log2_polynomial.sv
// ----------------------------------------------------------------------------
// fast_log2_polynomial: pipelined approximate logarithm of a float
// Exponent plus fifth-degree Horner correction, optional ln 2 scaling.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: the raw 32-bit float pattern.
//   o_out returns one item per input: log_value (signed, OUT_FRAC_BITS
//   fraction bits, clamped) and minus_infinity for zero or negative inputs.
//   i_cfg writes natural_log_mode (0: log2, 1: ln); it is always ready and
//   should only be written while no items are in flight.
//   The pipe takes one item every cycle while o_out is not stalled; the
//   depth includes the five Horner steps, each a 26x27 multiply stage
//   followed by a round-and-add stage.
//   All stages advance together: when the receiver holds o_out.ready low
//   with a result waiting, the whole pipe freezes and i_in.ready drops, so
//   nothing is lost or repeated. Bubbles flow through as cleared valid bits.
//   A synchronous active-low reset clears all valid bits and the mode
//   register; payload registers are not reset.
// ----------------------------------------------------------------------------
module fast_log2_polynomial #(
    parameter int OUT_FRAC_BITS = fl2p_pkg::OUT_FRAC_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    fl2p_in_if.sink     i_in,
    fl2p_cfg_if.sink    i_cfg,
    fl2p_out_if.source  o_out
);

    localparam int NS      = fl2p_pkg::NUM_STAGES;
    localparam int Q       = fl2p_pkg::Q;
    localparam int P_W     = fl2p_pkg::P_W;
    localparam int LOG_W   = fl2p_pkg::LOG_W;
    // Output fraction bits, held to 0..Q
    localparam int OFB     = (OUT_FRAC_BITS > Q) ? Q :
                             ((OUT_FRAC_BITS < 0) ? 0 : OUT_FRAC_BITS);
    localparam int SH      = Q - OFB;
    localparam longint HALF_OUT = (SH > 0) ? (longint'(1) << (SH - 1)) : longint'(0);
    localparam longint LIM_RAW  = longint'(129) << OFB;
    localparam longint FMAX     = (longint'(1) << 24) - 1;
    localparam longint LIM      = (LIM_RAW > FMAX) ? FMAX : LIM_RAW;
    localparam logic signed [33:0] LIM_S   = 34'(LIM);
    localparam logic signed [52:0] RND_Q   = 53'(longint'(1) << (Q - 1));

    // Stage indexes after the Horner section
    localparam int ST_FMUL = 11;
    localparam int ST_SUM  = 12;
    localparam int ST_LMUL = 13;

    // Mode register and pipeline control
    logic                 r_ln_mode;
    logic [NS-1:0]        r_vld;
    fl2p_pkg::t_ctx       r_ctx [NS];
    fl2p_pkg::t_ctx       n_ctx0;
    logic                 w_en;

    assign w_en        = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ln_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_ln_mode <= i_cfg.natural_log_mode;
        end
    end

    // Stage 0: split the float, flag zero and negative patterns
    always_comb begin
        n_ctx0.frac = i_in.float_bits[22:0];
        n_ctx0.expo = 9'($signed({1'b0, i_in.float_bits[30:23]})) - 9'sd127;
        n_ctx0.minf = i_in.float_bits[31] || (i_in.float_bits == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctx[0] <= n_ctx0;
            for (int j = 1; j < NS; j++) begin
                r_ctx[j] <= r_ctx[j-1];
            end
        end
    end

    // Horner steps: multiply by m, then round and add the next coefficient
    logic signed [52:0]    r_prod [1:5];
    logic signed [P_W-1:0] r_p    [1:5];

    for (genvar k = 1; k <= 5; k++) begin : g_horner
        logic signed [25:0]    w_m;
        logic signed [P_W-1:0] w_pin;
        logic signed [52:0]    n_prod;
        logic signed [52:0]    w_acc;
        logic signed [P_W-1:0] n_p;

        assign w_m = $signed({1'b0, 1'b1, r_ctx[2*k-2].frac, 1'b0});
        if (k == 1) begin : g_first
            assign w_pin = fl2p_pkg::COEF[0];
        end else begin : g_next
            assign w_pin = r_p[k-1];
        end
        assign n_prod = w_m * w_pin;
        assign w_acc  = r_prod[k] + (53'(fl2p_pkg::COEF[k]) <<< Q) + RND_Q;
        assign n_p    = w_acc[Q+P_W-1:Q];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_prod[k] <= n_prod;
                r_p[k]    <= n_p;
            end
        end
    end

    // Scale by (m - 1), then add the unbiased exponent
    logic signed [51:0] n_fprod;
    logic signed [51:0] r_fprod;
    logic signed [51:0] w_facc;
    logic signed [27:0] w_pc;
    logic signed [32:0] n_sum;
    logic signed [32:0] r_sum;

    assign n_fprod = r_p[5] * $signed({1'b0, r_ctx[ST_FMUL-1].frac, 1'b0});
    assign w_facc  = r_fprod + 52'(RND_Q);
    assign w_pc    = w_facc[51:Q];
    assign n_sum   = $signed({r_ctx[ST_SUM-1].expo, 24'd0}) + 33'(w_pc);

    // Natural-log scaling by ln 2
    logic signed [57:0] n_lprod;
    logic signed [57:0] r_lprod;
    logic signed [32:0] r_s13;
    logic signed [57:0] w_lacc;
    logic signed [32:0] w_lrnd;
    logic signed [32:0] n_s14;
    logic signed [32:0] r_s14;

    assign n_lprod = r_sum * fl2p_pkg::LN2_Q24;
    assign w_lacc  = r_lprod + 58'(RND_Q);
    assign w_lrnd  = w_lacc[Q+32:Q];
    assign n_s14   = r_ln_mode ? w_lrnd : r_s13;

    // Output rounding and clamping
    logic signed [33:0]      w_racc;
    logic signed [33:0]      w_rnd;
    logic signed [LOG_W-1:0] n_out;
    logic signed [LOG_W-1:0] r_out;

    assign w_racc = 34'(r_s14) + 34'(HALF_OUT);
    assign w_rnd  = w_racc >>> SH;

    always_comb begin
        priority if (r_ctx[NS-2].minf) begin
            n_out = LOG_W'(-LIM_S);
        end else if (w_rnd > LIM_S) begin
            n_out = LOG_W'(LIM_S);
        end else if (w_rnd < -LIM_S) begin
            n_out = LOG_W'(-LIM_S);
        end else begin
            n_out = LOG_W'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fprod <= n_fprod;
            r_sum   <= n_sum;
            r_lprod <= n_lprod;
            r_s13   <= r_sum;
            r_s14   <= n_s14;
            r_out   <= n_out;
        end
    end

    assign o_out.valid          = r_vld[NS-1];
    assign o_out.log_value      = r_out;
    assign o_out.minus_infinity = r_ctx[NS-1].minf;

`ifndef NO_ASSERTIONS
    // A minus-infinity result always carries the negative clamp limit
    a_minf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.minus_infinity) |-> (o_out.log_value == LOG_W'(-LIM_S)))
        else $error("minus_infinity result without the negative limit");

    // Results stay inside the clamp range
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((34'(o_out.log_value) <= LIM_S) && (34'(o_out.log_value) >= -LIM_S)))
        else $error("log_value outside the clamp range");

    // In log2 mode the ln 2 stage passes a valid item's sum through unchanged
    a_log2_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_ln_mode && r_vld[ST_LMUL]) |=> (r_s14 == $past(r_s13)))
        else $error("ln 2 stage altered the sum in log2 mode");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");
`endif

endmodule
